// ----- hw/rtl/seiude_pkg.sv -----
// Shared types and constants for the SEI user data extractor.
package seiude_pkg;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_LEN     = 7'b0000010,
    PH_HDR     = 7'b0000100,
    PH_SEITYPE = 7'b0001000,
    PH_SIZE    = 7'b0010000,
    PH_UUID    = 7'b0100000,
    PH_PAYLOAD = 7'b1000000
  } phase_t;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_CUSTOM  = 2'd1;
  localparam logic [1:0] KIND_IGNORED = 2'd2;
  localparam logic [1:0] KIND_END     = 2'd3;

  localparam logic [1:0] CFG_SEI_TYPE    = 2'd0;
  localparam logic [1:0] CFG_CUSTOM_TYPE = 2'd1;
  localparam logic [1:0] CFG_UUID_SKIP   = 2'd2;

  localparam logic [4:0]  SEI_NAL_TYPE = 5'd6;
  localparam logic [7:0]  EP_BYTE      = 8'h03;
  localparam logic [7:0]  FF_BYTE      = 8'hFF;
  localparam logic [31:0] SIZE_MAX     = 32'hFFFF_FFFF;
  localparam logic [31:0] FF_WEIGHT    = 32'd255;

  typedef struct packed {
    logic [4:0] sei_type_match;
    logic [4:0] custom_nal_type;
    logic [7:0] uuid_skip_length;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [31:0] size_value;
    logic        last;
  } result_t;

endpackage

// ----- hw/rtl/seiude_parser.sv -----
// Per-byte parser state and result logic for one H.264 sample.
module seiude_parser #(
  parameter int LENGTH_PREFIX_BYTES = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         data_byte,
  input  logic               sample_start,
  input  seiude_pkg::cfg_t   cfg,
  output logic               res_valid,
  output seiude_pkg::result_t res
);

  localparam int CW = (LENGTH_PREFIX_BYTES > 1) ? $clog2(LENGTH_PREFIX_BYTES) : 1;
  localparam logic [CW-1:0] LEN_LAST = CW'(LENGTH_PREFIX_BYTES - 1);

  seiude_pkg::phase_t phase, phase_next;
  logic [CW-1:0] len_cnt, len_cnt_next;
  logic [31:0]   nal_length, nal_length_next;
  logic [31:0]   ff_sum, ff_sum_next;        // 255 * ff_count, saturating
  logic [31:0]   payload_left, payload_left_next;
  logic [31:0]   announced, announced_next;
  logic [7:0]    uuid_left, uuid_left_next;
  logic [1:0]    zero_run, zero_run_next;

  always_comb begin
    seiude_pkg::phase_t ph;
    logic [CW-1:0] cnt_cur;
    logic [31:0]   nal_cur;
    logic [4:0]    t;
    logic [32:0]   total;
    logic signed [8:0]  bu;
    logic signed [33:0] diff;
    logic [31:0]   ann;
    logic [31:0]   pl_dec;
    logic [7:0]    uuid_dec;

    ph      = sample_start ? seiude_pkg::PH_LEN : phase;
    cnt_cur = sample_start ? '0 : len_cnt;
    nal_cur = sample_start ? '0 : nal_length;
    t       = data_byte[4:0];
    total   = {1'b0, ff_sum} + {25'd0, data_byte};
    bu      = $signed({1'b0, data_byte}) - $signed({1'b0, cfg.uuid_skip_length});
    diff    = $signed({2'b00, ff_sum}) + 34'(bu);
    pl_dec  = payload_left - 32'd1;
    uuid_dec = uuid_left - 8'd1;
    if (total[32] || total[31:0] == seiude_pkg::SIZE_MAX) begin
      ann = seiude_pkg::SIZE_MAX - {24'd0, cfg.uuid_skip_length};
    end else if (!diff[33] && diff != '0) begin
      ann = diff[31:0];
    end else begin
      ann = '0;
    end

    phase_next        = ph;
    len_cnt_next      = cnt_cur;
    nal_length_next   = nal_cur;
    ff_sum_next       = ff_sum;
    payload_left_next = payload_left;
    announced_next    = announced;
    uuid_left_next    = uuid_left;
    zero_run_next     = zero_run;
    res_valid         = 1'b0;
    res               = '0;

    case (ph)
      seiude_pkg::PH_IDLE: begin
      end
      seiude_pkg::PH_LEN: begin
        nal_length_next = {nal_cur[23:0], data_byte};
        len_cnt_next    = cnt_cur + CW'(1);
        if (cnt_cur == LEN_LAST) begin
          phase_next = seiude_pkg::PH_HDR;
        end
      end
      seiude_pkg::PH_HDR: begin
        zero_run_next = '0;
        if (nal_cur != '0 && t == cfg.custom_nal_type) begin
          phase_next      = seiude_pkg::PH_IDLE;
          res_valid       = 1'b1;
          res.kind        = seiude_pkg::KIND_CUSTOM;
          res.size_value  = nal_cur - 32'd1;
          res.last        = 1'b1;
        end else if (nal_cur != '0 && t == seiude_pkg::SEI_NAL_TYPE) begin
          phase_next = seiude_pkg::PH_SEITYPE;
        end else begin
          phase_next = seiude_pkg::PH_IDLE;
          res_valid  = 1'b1;
          res.kind   = seiude_pkg::KIND_IGNORED;
          res.last   = 1'b1;
        end
      end
      default: begin
        // 00 00 03: drop the emulation-prevention byte
        if (zero_run == 2'd2 && data_byte == seiude_pkg::EP_BYTE) begin
          zero_run_next = '0;
        end else begin
          if (data_byte == 8'd0) begin
            zero_run_next = (zero_run == 2'd2) ? 2'd2 : zero_run + 2'd1;
          end else begin
            zero_run_next = '0;
          end
          case (ph)
            seiude_pkg::PH_SEITYPE: begin
              if (t == cfg.sei_type_match) begin
                ff_sum_next = '0;
                phase_next  = seiude_pkg::PH_SIZE;
              end else begin
                phase_next = seiude_pkg::PH_IDLE;
                res_valid  = 1'b1;
                res.kind   = seiude_pkg::KIND_IGNORED;
                res.last   = 1'b1;
              end
            end
            seiude_pkg::PH_SIZE: begin
              if (data_byte == seiude_pkg::FF_BYTE) begin
                ff_sum_next = (ff_sum > seiude_pkg::SIZE_MAX - seiude_pkg::FF_WEIGHT) ?
                              seiude_pkg::SIZE_MAX : ff_sum + seiude_pkg::FF_WEIGHT;
              end else begin
                announced_next    = ann;
                payload_left_next = ann;
                if (cfg.uuid_skip_length == '0) begin
                  if (ann == '0) begin
                    phase_next     = seiude_pkg::PH_IDLE;
                    res_valid      = 1'b1;
                    res.kind       = seiude_pkg::KIND_END;
                    res.size_value = ann;
                    res.last       = 1'b1;
                  end else begin
                    phase_next = seiude_pkg::PH_PAYLOAD;
                  end
                end else begin
                  uuid_left_next = cfg.uuid_skip_length;
                  phase_next     = seiude_pkg::PH_UUID;
                end
              end
            end
            seiude_pkg::PH_UUID: begin
              uuid_left_next = uuid_dec;
              if (uuid_dec == '0) begin
                if (payload_left == '0) begin
                  phase_next     = seiude_pkg::PH_IDLE;
                  res_valid      = 1'b1;
                  res.kind       = seiude_pkg::KIND_END;
                  res.size_value = announced;
                  res.last       = 1'b1;
                end else begin
                  phase_next = seiude_pkg::PH_PAYLOAD;
                end
              end
            end
            seiude_pkg::PH_PAYLOAD: begin
              res_valid         = 1'b1;
              res.kind          = seiude_pkg::KIND_PAYLOAD;
              res.payload_byte  = data_byte;
              res.size_value    = announced;
              res.last          = (payload_left == 32'd1);
              payload_left_next = pl_dec;
              if (pl_dec == '0) begin
                phase_next = seiude_pkg::PH_IDLE;
              end
            end
            default: begin
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= seiude_pkg::PH_IDLE;
      len_cnt      <= '0;
      nal_length   <= '0;
      ff_sum       <= '0;
      payload_left <= '0;
      announced    <= '0;
      uuid_left    <= '0;
      zero_run     <= '0;
    end else if (step) begin
      phase        <= phase_next;
      len_cnt      <= len_cnt_next;
      nal_length   <= nal_length_next;
      ff_sum       <= ff_sum_next;
      payload_left <= payload_left_next;
      announced    <= announced_next;
      uuid_left    <= uuid_left_next;
      zero_run     <= zero_run_next;
    end
  end

endmodule

// ----- hw/rtl/sei_user_data_extractor.sv -----
// Top level: stream ports, configuration registers, input and result stages.
//
// Input stream s_*: one sample byte per beat in s_tdata; s_tuser set on the
// first byte of a sample restarts the parser. Bytes before the first sample
// start, and bytes after a sample's outcome is settled, give no result.
// Output stream m_*: at most one result per input beat. m_tuser is the kind
// (payload byte, custom NAL size, NAL ignored, empty payload end), m_tdata
// carries the payload byte and the size, m_tlast marks the sample's final
// result. Configuration: cfg_we with cfg_index/cfg_data writes one register
// at the clock edge; the user must write only while the block is idle, as
// the block itself does not enforce it. Results pass the input register and
// the result register. Throughput: one byte per cycle unless the receiver
// stalls; the per-byte work is a single pass between the two registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more beat; s_tready drops once both are full.
// Reset (rst, synchronous) empties both stages, returns the parser to waiting
// for a sample start and restores the register defaults (type 5, custom 0,
// UUID 16 bytes).
module sei_user_data_extractor #(
  parameter int LENGTH_PREFIX_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] sample_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] payload_byte, [39:8] size_value
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  seiude_pkg::cfg_t    cfg;
  seiude_pkg::result_t res, out_res;
  logic                res_valid;
  logic                in_valid;
  logic [7:0]          in_byte;
  logic                in_start;
  logic                out_valid;
  logic                advance;
  logic                step;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sei_type_match   <= 5'd5;
      cfg.custom_nal_type  <= 5'd0;
      cfg.uuid_skip_length <= 8'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        seiude_pkg::CFG_SEI_TYPE:    cfg.sei_type_match   <= cfg_data[4:0];
        seiude_pkg::CFG_CUSTOM_TYPE: cfg.custom_nal_type  <= cfg_data[4:0];
        seiude_pkg::CFG_UUID_SKIP:   cfg.uuid_skip_length <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign step     = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte  <= s_tdata;
      in_start <= s_tuser;
    end
  end

  seiude_parser #(
    .LENGTH_PREFIX_BYTES(LENGTH_PREFIX_BYTES)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .data_byte    (in_byte),
    .sample_start (in_start),
    .cfg          (cfg),
    .res_valid    (res_valid),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.size_value, out_res.payload_byte};
  assign m_tuser  = out_res.kind;
  assign m_tlast  = out_res.last;

`ifndef ASSERT_OFF
  a_reset_empties: assert property (@(posedge clk)
    rst |=> !m_tvalid && !in_valid)
    else $error("stages not empty after reset");

  a_in_holds: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte) && $stable(in_start))
    else $error("input stage lost a beat while stalled");

  a_report_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != seiude_pkg::KIND_PAYLOAD |-> m_tlast)
    else $error("report without last");

  a_ignored_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == seiude_pkg::KIND_IGNORED |-> m_tdata == '0)
    else $error("ignored report carries data");
`endif

endmodule
